/* hw/rtl/parf_pkg.sv */
// Shared types and constants for the ratio-fit pool allocator.
package parf_pkg;

   localparam int POOL_DEPTH_DEF = 16;

   localparam logic [8:0] RATIO_RESET = 9'd192;
   localparam logic [8:0] RATIO_MAX   = 9'd256;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] ST_REUSED  = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_FREED   = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture the accepted request, rewind the index
      logic       rd;         // read the active list
      logic       rd_plus1;   // read at index + 1 instead of index
      logic       hold;       // latch the read entry and its scaled size
      logic       idx_inc;    // advance the index
      logic       shift_wr;   // write the entry read at index + 1 back at index
      logic       move;       // move the latched entry to the other list
      logic       new_blk;    // record a block with a fresh handle
      logic       clr_free;   // empty the free list
      logic       res_load;   // load the output register
      logic [2:0] res_status; // status of the result being loaded
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       used_full;
      logic       used_empty;
      logic       free_full;
      logic       free_empty;
      logic       fit;        // latched free block fits the request
      logic       match;      // latched in-use block carries the handle
      logic       idx_last;   // index is the last entry of the active list
      logic       out_free;   // output register can take a result
   } stat_type;

endpackage

/* hw/rtl/pool_allocator_ratio_fit_core.sv */
// Top level of the ratio-fit pool allocator: controller plus datapath.
//
//   Channel  Direction  Transfer when            Contents
//   req_*    in         req_tvalid & req_tready  tuser: operation; tdata: size, handle
//   rsp_*    out        rsp_tvalid & rsp_tready  tuser: status; tdata: handle, size
//   csr_*    in         csr_wr_en                csr_wr_data: fit ratio in 1/256 units
//
// One request at a time; a request is taken only in the idle state, after the result
// load or an ignored operation. A scan reads, latches and compares each entry of the
// active list; a hit shifts the later entries down and moves the block, an allocate
// with no fit records a new block, and a free hit on a full free list is refused.
// Synchronous reset clears the counts and sets the handle counter to 1 and the ratio to 192.
// A result not yet taken stalls the next result load and, with it, the next request.
module pool_allocator_ratio_fit_core import parf_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] request_size, [63:32] block_handle
   input  logic [1:0]  req_tuser,  // [1:0] operation
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [31:0] result_handle, [63:32] granted_size
   output logic [2:0]  rsp_tuser,  // [2:0] status
   // Ratio register write port.
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;
   logic [63:0] rsp_word;

   // The controller steps through decode, list scan, compaction and result
   // load, driving the datapath with one command word per cycle.
   parf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath keeps both lists in memories as {handle, size} words.
   parf_dp #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_word),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   // The stored word carries the size in its low half; the result puts the
   // handle first.
   assign rsp_tdata = {rsp_word[31:0], rsp_word[63:32]};

endmodule

/* hw/rtl/parf_dp.sv */
// Datapath of the pool allocator: both lists, counters, fit check and output register.
module parf_dp import parf_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   input  cmd_type     cmd,
   output stat_type    stat
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

   // Each entry holds the handle in the upper half and the size in the lower half.
   logic [63:0] free_mem [POOL_DEPTH];
   logic [63:0] used_mem [POOL_DEPTH];

   logic [63:0]      free_rd_ff, used_rd_ff;
   logic [63:0]      entry_ff, entry_in;
   logic [40:0]      prod_ff;
   logic [1:0]       op_ff;
   logic [31:0]      req_size_ff, handle_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in, used_cnt_ff, used_cnt_in;
   logic [31:0]      fresh_ff, fresh_in, fresh_inc;
   logic [8:0]       ratio_ff, ratio_cl;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff;
   logic [2:0]       rsp_user_ff;

   logic             list_used;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W-1:0] idx_p1, cnt_sel;
   logic [63:0]      rd_sel;
   logic             free_we, used_we;
   logic [IDX_W-1:0] free_wa, used_wa;
   logic [63:0]      free_wd, used_wd;

   assign list_used = (op_ff == OP_FREE);
   assign rd_addr   = cmd.rd_plus1 ? IDX_W'(idx_ff + 1'b1) : idx_ff;
   assign idx_p1    = CNT_W'(idx_ff) + CNT_W'(1);
   assign cnt_sel   = list_used ? used_cnt_ff : free_cnt_ff;
   assign rd_sel    = list_used ? used_rd_ff : free_rd_ff;
   assign ratio_cl  = (ratio_ff > RATIO_MAX) ? RATIO_MAX : ratio_ff;
   assign fresh_inc = fresh_ff + 32'd1;

   // Write ports of the two lists.
   always_comb begin
      free_we = 1'b0;
      free_wa = idx_ff;
      free_wd = free_rd_ff;
      used_we = 1'b0;
      used_wa = idx_ff;
      used_wd = used_rd_ff;
      if (cmd.shift_wr) begin
         free_we = !list_used;
         used_we = list_used;
      end else if (cmd.move && list_used) begin
         free_we = 1'b1;
         free_wa = free_cnt_ff[IDX_W-1:0];
         free_wd = entry_ff;
      end else if (cmd.move) begin
         used_we = 1'b1;
         used_wa = used_cnt_ff[IDX_W-1:0];
         used_wd = entry_ff;
      end else if (cmd.new_blk) begin
         used_we = 1'b1;
         used_wa = used_cnt_ff[IDX_W-1:0];
         used_wd = {fresh_ff, req_size_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      if (cmd.rd && !list_used) begin
         free_rd_ff <= free_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (cmd.rd && list_used) begin
         used_rd_ff <= used_mem[rd_addr];
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.hold) begin
         entry_in = rd_sel;
      end else if (cmd.new_blk) begin
         entry_in = {fresh_ff, req_size_ff};
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.hold) begin
         prod_ff <= 41'(rd_sel[31:0]) * 41'(ratio_cl);
      end
      if (cmd.load) begin
         op_ff       <= req_tuser;
         req_size_ff <= req_tdata[31:0];
         handle_ff   <= req_tdata[63:32];
      end
      if (cmd.res_load) begin
         rsp_user_ff <= cmd.res_status;
         if (cmd.res_status == ST_REUSED || cmd.res_status == ST_NEW ||
             cmd.res_status == ST_FREED) begin
            rsp_data_ff <= entry_ff;
         end else begin
            rsp_data_ff <= 64'd0;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
      end

      free_cnt_in = free_cnt_ff;
      used_cnt_in = used_cnt_ff;
      if (cmd.clr_free) begin
         free_cnt_in = '0;
      end else if (cmd.move && list_used) begin
         free_cnt_in = free_cnt_ff + CNT_W'(1);
         used_cnt_in = used_cnt_ff - CNT_W'(1);
      end else if (cmd.move) begin
         free_cnt_in = free_cnt_ff - CNT_W'(1);
         used_cnt_in = used_cnt_ff + CNT_W'(1);
      end else if (cmd.new_blk) begin
         used_cnt_in = used_cnt_ff + CNT_W'(1);
      end

      fresh_in = fresh_ff;
      if (cmd.new_blk) begin
         fresh_in = (fresh_inc == 32'd0) ? 32'd1 : fresh_inc;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         free_cnt_ff  <= '0;
         used_cnt_ff  <= '0;
         fresh_ff     <= 32'd1;
         ratio_ff     <= RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ratio_ff <= csr_wr_data;
         end
      end
   end

   assign stat.op         = op_ff;
   assign stat.used_full  = (used_cnt_ff == DEPTH_CNT);
   assign stat.used_empty = (used_cnt_ff == '0);
   assign stat.free_full  = (free_cnt_ff == DEPTH_CNT);
   assign stat.free_empty = (free_cnt_ff == '0);
   assign stat.fit        = (entry_ff[31:0] >= req_size_ff) &&
                            (prod_ff[40:8] <= {1'b0, req_size_ff});
   assign stat.match      = (entry_ff[63:32] == handle_ff);
   assign stat.idx_last   = (idx_p1 == cnt_sel);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* hw/rtl/parf_ctrl.sv */
// Controller of the pool allocator: sequences scans, compaction and result loads.
module parf_ctrl import parf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_RD     = 10'b00_0000_0100,
      S_LD     = 10'b00_0000_1000,
      S_CMP    = 10'b00_0001_0000,
      S_SH_CHK = 10'b00_0010_0000,
      S_SH_WR  = 10'b00_0100_0000,
      S_FIN    = 10'b00_1000_0000,
      S_NEW    = 10'b01_0000_0000,
      S_RES    = 10'b10_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic       is_alloc, hit;

   assign is_alloc   = (stat.op == OP_ALLOC);
   assign hit        = is_alloc ? stat.fit : stat.match;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_ALLOC: begin
                  if (stat.used_full) begin
                     kind_in  = ST_FULL;
                     state_in = S_RES;
                  end else if (stat.free_empty) begin
                     state_in = S_NEW;
                  end else begin
                     state_in = S_RD;
                  end
               end
               OP_FREE: begin
                  if (stat.used_empty) begin
                     kind_in  = ST_UNKNOWN;
                     state_in = S_RES;
                  end else begin
                     state_in = S_RD;
                  end
               end
               OP_CLEAR: begin
                  cmd.clr_free = 1'b1;
                  kind_in      = ST_CLEARED;
                  state_in     = S_RES;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LD;
         end
         S_LD: begin
            cmd.hold = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit) begin
               if (!is_alloc && stat.free_full) begin
                  kind_in  = ST_FULL;
                  state_in = S_RES;
               end else begin
                  state_in = S_SH_CHK;
               end
            end else if (stat.idx_last) begin
               if (is_alloc) begin
                  state_in = S_NEW;
               end else begin
                  kind_in  = ST_UNKNOWN;
                  state_in = S_RES;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RD;
            end
         end
         S_SH_CHK: begin
            if (stat.idx_last) begin
               state_in = S_FIN;
            end else begin
               cmd.rd       = 1'b1;
               cmd.rd_plus1 = 1'b1;
               state_in     = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SH_CHK;
         end
         S_FIN: begin
            cmd.move = 1'b1;
            kind_in  = is_alloc ? ST_REUSED : ST_FREED;
            state_in = S_RES;
         end
         S_NEW: begin
            cmd.new_blk = 1'b1;
            kind_in     = ST_NEW;
            state_in    = S_RES;
         end
         S_RES: begin
            if (stat.out_free) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = kind_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ST_CLEARED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

/* verif/pool_alloc_checker.sv */
// Checker for the ratio-fit pool allocator: mirrors both block lists and compares every result.
`timescale 1ns / 1ps

module pool_alloc_checker import parf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] request_size, [63:32] block_handle
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] result_handle, [63:32] granted_size
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [31:0] size;
      logic [31:0] handle;
   } pool_block_type;

   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] size;
      logic [2:0]  status;
   } grant_type;

   pool_block_type free_blocks [POOL_DEPTH_DEF];
   pool_block_type used_blocks [POOL_DEPTH_DEF];
   int          free_count;
   int          used_count;
   logic [31:0] fresh_handle;
   logic [8:0]  fit_ratio;
   grant_type   expected_grants [$];
   int          failures = 0;

   function automatic grant_type make_grant(input logic [31:0] h, input logic [31:0] s,
                                            input logic [2:0] st);
      grant_type g;
      g.handle = h;
      g.size   = s;
      g.status = st;
      return g;
   endfunction

   // A block fits when it is large enough and its scaled size does not exceed the request.
   function automatic bit block_fits(input logic [31:0] block_size, input logic [31:0] want,
                                     input logic [8:0] r);
      logic [63:0] scaled;
      scaled = (64'(block_size) * 64'(r)) >> 8;
      return (block_size >= want) && (scaled <= 64'(want));
   endfunction

   // Applies one request to the mirrored pool; returns 0 when the request yields no result.
   function automatic bit serve_request(input logic [1:0] op, input logic [31:0] want_size,
                                        input logic [31:0] handle, output grant_type g);
      int             hit;
      bit             produced;
      pool_block_type blk;
      logic [8:0]     r;
      hit      = -1;
      produced = 1'b1;
      blk      = '0;
      g        = '0;
      r        = (fit_ratio > RATIO_MAX) ? RATIO_MAX : fit_ratio;
      case (op)
         OP_ALLOC: begin
            if (used_count >= POOL_DEPTH_DEF) begin
               g = make_grant(32'd0, 32'd0, ST_FULL);
            end else begin
               for (int i = 0; i < free_count; i++)
                  if (hit < 0 && block_fits(free_blocks[i].size, want_size, r))
                     hit = i;
               if (hit >= 0) begin
                  blk = free_blocks[hit];
                  for (int j = hit; j + 1 < free_count; j++)
                     free_blocks[j] = free_blocks[j + 1];
                  free_count--;
                  g = make_grant(blk.handle, blk.size, ST_REUSED);
               end else begin
                  blk.size   = want_size;
                  blk.handle = fresh_handle;
                  // The counter never hands out handle zero.
                  fresh_handle = (fresh_handle == 32'hFFFF_FFFF) ? 32'd1 : fresh_handle + 32'd1;
                  g = make_grant(blk.handle, blk.size, ST_NEW);
               end
               used_blocks[used_count] = blk;
               used_count++;
            end
         end
         OP_FREE: begin
            for (int i = 0; i < used_count; i++)
               if (hit < 0 && used_blocks[i].handle == handle)
                  hit = i;
            if (hit < 0) begin
               g = make_grant(32'd0, 32'd0, ST_UNKNOWN);
            end else if (free_count >= POOL_DEPTH_DEF) begin
               g = make_grant(32'd0, 32'd0, ST_FULL);
            end else begin
               blk = used_blocks[hit];
               for (int j = hit; j + 1 < used_count; j++)
                  used_blocks[j] = used_blocks[j + 1];
               used_count--;
               free_blocks[free_count] = blk;
               free_count++;
               g = make_grant(blk.handle, blk.size, ST_FREED);
            end
         end
         OP_CLEAR: begin
            free_count = 0;
            g = make_grant(32'd0, 32'd0, ST_CLEARED);
         end
         default: begin
            produced = 1'b0;
         end
      endcase
      return produced;
   endfunction

   always @(posedge clock) begin : track
      grant_type predicted;
      grant_type oldest;
      grant_type seen;
      if (reset) begin
         fit_ratio    = RATIO_RESET;
         free_count   = 0;
         used_count   = 0;
         fresh_handle = 32'd1;
         expected_grants.delete();
      end else begin
         if (csr_wr_en)
            fit_ratio = csr_wr_data;
         // Results are checked before the new request is predicted, so that a result
         // arriving on the same edge is matched against an older request.
         if (rsp_tvalid && rsp_tready) begin
            seen = make_grant(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
            if (expected_grants.size() == 0) begin
               failures++;
               $display("%0t: unexpected result: expected none, actual %h %h %0d",
                        $time, seen.handle, seen.size, seen.status);
            end else begin
               oldest = expected_grants.pop_front();
               if (seen !== oldest) begin
                  failures++;
                  // Values are handle, size and status.
                  $display("%0t: result mismatch: expected %h %h %0d, actual %h %h %0d",
                           $time, oldest.handle, oldest.size, oldest.status,
                           seen.handle, seen.size, seen.status);
               end
            end
         end
         if (req_tvalid && req_tready)
            if (serve_request(req_tuser, req_tdata[31:0], req_tdata[63:32], predicted))
               expected_grants.insert(expected_grants.size(), predicted);
      end
      pending_count  <= expected_grants.size();
      mismatch_count <= failures;
   end

endmodule

/* verif/testbench.sv */
// Testbench top for the ratio-fit pool allocator: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
   import parf_pkg::*;

   // Operation code that the block accepts and ignores.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam int RESET_CYCLES  = 11;
   localparam int PHASES        = 30;
   localparam int PHASE_ITEMS   = 65;
   localparam int CALM_PHASES   = 4;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_PHASE    = 4;
   localparam int WATCHDOG_MAX  = 4000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [8:0]  csr_wr_data = RATIO_RESET;

   int          mismatch_count;
   int          pending_count;

   // Set by the stimulus when no more idling is wanted on either side.
   bit          calm    = 1'b0;
   // Set once by the stimulus to ask the receiver for its long hold-off.
   bit          hold_go = 1'b0;
   int          idle_cycles = 0;

   // Handles that came back granted; frees mostly draw from here so they hit.
   logic [31:0] live_handles [$];

   // Ratio corners: zero, one, 255, exact-size-only, clamped values above 256, and the reset value.
   logic [8:0]  ratio_corners [7] = '{9'd0, 9'd256, 9'd511, 9'd257, 9'd1, 9'd255, RATIO_RESET};

   // Percentage of allocates per phase style: filling, draining, balanced.
   int          alloc_pct [3] = '{78, 15, 48};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   pool_allocator_ratio_fit_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pool_alloc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Result receiver. Each pass sets tready once and then waits at least one edge, so
   // tready never sees two assignments in one time step.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            // Long hold-off: the output register fills and the request side stalls.
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired after %0d cycles without a transfer",
                     $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Collect granted handles for later frees; the list is kept short.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready &&
          (rsp_tuser == ST_NEW || rsp_tuser == ST_REUSED)) begin
         live_handles.insert(live_handles.size(), rsp_tdata[31:0]);
         if (live_handles.size() > 48)
            live_handles.delete(0);
      end
   end

   // Sizes mostly cluster around multiples of 64 so that ratio fits both hit and miss;
   // the rest are zero, all ones, or fully random to reach the wide product.
   function automatic logic [31:0] pick_size();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0:       s = 32'd0;
         1:       s = 32'hFFFF_FFFF;
         2, 3:    s = $urandom;
         default: s = $urandom_range(1, 12) * 64 - $urandom_range(0, 48);
      endcase
      return s;
   endfunction

   // Frees mostly target a handle that was granted; the rest are likely unknown.
   function automatic logic [31:0] pick_handle();
      int          k;
      logic [31:0] h;
      k = $urandom_range(0, 9);
      if (k < 8 && live_handles.size() > 0) begin
         k = $urandom_range(0, live_handles.size() - 1);
         h = live_handles[k];
         live_handles.delete(k);
      end else if (k == 9) begin
         h = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      end else begin
         h = $urandom;
      end
      return h;
   endfunction

   // Offers one request and returns at the edge where it is transferred.
   task automatic send_req(input logic [1:0] op, input logic [31:0] size,
                           input logic [31:0] handle);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {handle, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering, waits for every outstanding result, then lets the block go quiet.
   // The extra cycles cover an ignored request that never produces a result.
   task automatic wait_pool_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [8:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int          style;
      int          roll;
      logic [1:0]  op;
      logic [31:0] handle;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset ratio. Handles follow from the fresh counter.
      send_req(OP_FREE, 32'd0, 32'd5);                         // free on an empty pool
      send_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // clear an empty free list
      send_req(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // ignored operation
      send_req(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);                // new block 1, size zero
      send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);                // new block 2, largest size
      send_req(OP_ALLOC, 32'd1000, 32'd0);                     // new block 3
      send_req(OP_FREE, 32'd0, 32'd2);
      send_req(OP_FREE, 32'd0, 32'd3);
      send_req(OP_FREE, 32'd0, 32'd1);
      send_req(OP_FREE, 32'd0, 32'd3);                         // double free is unknown
      send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);                // reuse of the largest block
      send_req(OP_ALLOC, 32'd760, 32'd0);                      // reuse just inside the ratio
      send_req(OP_ALLOC, 32'd749, 32'd0);                      // no free block fits, so a new block
      send_req(OP_FREE, 32'd0, 32'd4);
      send_req(OP_ALLOC, 32'd0, 32'd0);                        // zero-size block is reused
      send_req(OP_CLEAR, 32'd0, 32'd0);                        // drops a pending free block
      send_req(OP_ALLOC, 32'd749, 32'd0);                      // cleared block not reused
      send_req(OP_FREE, 32'hFFFF_FFFF, 32'd0);                 // handle zero is never valid
      send_req(OP_FREE, 32'd0, 32'hFFFF_FFFF);
      send_req(OP_IGNORED, 32'd0, 32'd0);
      wait_pool_idle();

      // Random phases. Each starts from an idle pool with a new ratio; styles alternate
      // between filling the in-use list, draining it into the free list, and a balance,
      // so that both full-list refusals occur with live contents.
      for (int p = 0; p < PHASES; p++) begin
         write_ratio((p < 7) ? ratio_corners[p] : 9'($urandom_range(0, 511)));
         calm  = (p >= PHASES - CALM_PHASES);
         style = p % 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == HOLD_PHASE && n == 10)
               hold_go = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct[style])
               op = OP_ALLOC;
            else if (roll < 96)
               op = OP_FREE;
            else if (roll < 98)
               op = OP_CLEAR;
            else
               op = OP_IGNORED;
            handle = (op == OP_FREE) ? pick_handle() : $urandom;
            send_req(op, pick_size(), handle);
         end
         wait_pool_idle();
      end

      if (mismatch_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
